[hw/rtl/asrl_pkg.sv]
// ----------------------------------------------------------------------------
// asrl_pkg
// Shared widths, register indexes and the configuration bundle of the
// asymmetric slew-rate limiter.
// ----------------------------------------------------------------------------
package asrl_pkg;

    localparam int DATA_W      = 32;
    localparam int STEP_W      = 31;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RISE_STEP = 2'd0,
        REG_FALL_STEP = 2'd1,
        REG_SIGN_MODE = 2'd2,
        REG_ZERO_PASS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [STEP_W-1:0] rise_step;
        logic [STEP_W-1:0] fall_step;
        logic              sign_mode;
        logic              zero_pass;
    } cfg_t;

endpackage

[hw/rtl/asymmetric_slew_rate_limiter.sv]
// ----------------------------------------------------------------------------
// asymmetric_slew_rate_limiter
// Rate-limits a signed command stream with separate rise and fall steps,
// in magnitude or plain direction mode, with optional zero passthrough.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Direction
//  input     in_valid, in_stall, target       beat in
//  output    out_valid, out_stall, limited    beat out
//  config    cfg_wr_en, cfg_index, cfg_wdata  register write
//
//  A beat passes from acceptance to its result through the input register
//  and the result register. Unless stalled, one beat is accepted every cycle.
//  The last output is held in its own register, so the next beat is limited
//  against it while a result still waits in the result register.
//  Reset clears the control state, the configuration and the primed flag.
//  A stall on the output holds the result register and backs up into the
//  input register, which then stalls the input.
// ----------------------------------------------------------------------------
module asymmetric_slew_rate_limiter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [asrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [asrl_pkg::STEP_W-1:0]         cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [asrl_pkg::DATA_W-1:0]  target,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [asrl_pkg::DATA_W-1:0]  limited
);

    asrl_pkg::cfg_t              cfg;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [asrl_pkg::DATA_W-1:0] s1_target_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [asrl_pkg::DATA_W-1:0] limited_reg;
    logic [asrl_pkg::DATA_W-1:0] last_output_reg;
    logic                        primed_reg;
    logic [asrl_pkg::DATA_W-1:0] step_result;
    logic                        out_free;
    logic                        s1_fire;
    logic                        in_fire;

    asrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    asrl_step u_step (
        .target      (s1_target_reg),
        .last_output (last_output_reg),
        .primed      (primed_reg),
        .cfg         (cfg),
        .limited     (step_result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            primed_reg      <= 1'b0;
            last_output_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                primed_reg      <= 1'b1;
                last_output_reg <= step_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_target_reg <= target;
        end
        if (s1_fire)
        begin
            limited_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign limited   = limited_reg;

`ifndef SYNTHESIS
    a_first_passes: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !primed_reg |=> limited_reg == $past(s1_target_reg))
        else $error("first beat after reset was not passed through");

    a_last_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> last_output_reg == limited_reg)
        else $error("last output differs from the pending result");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled while a stage was free");

    a_primed_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> primed_reg)
        else $error("primed flag not set after a beat");
`endif

endmodule

[hw/rtl/asrl_cfg.sv]
// ----------------------------------------------------------------------------
// asrl_cfg
// Configuration register file: decodes the write port into the step sizes
// and mode bits.
// ----------------------------------------------------------------------------
module asrl_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [asrl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [asrl_pkg::STEP_W-1:0]         cfg_wdata,
    output asrl_pkg::cfg_t                      cfg
);

    asrl_pkg::cfg_t cfg_reg;
    asrl_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (asrl_pkg::cfg_index_t'(cfg_index))
                asrl_pkg::REG_RISE_STEP: cfg_next.rise_step = cfg_wdata;
                asrl_pkg::REG_FALL_STEP: cfg_next.fall_step = cfg_wdata;
                asrl_pkg::REG_SIGN_MODE: cfg_next.sign_mode = cfg_wdata[0];
                asrl_pkg::REG_ZERO_PASS: cfg_next.zero_pass = cfg_wdata[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/asrl_step.sv]
// ----------------------------------------------------------------------------
// asrl_step
// Limiting datapath: one subtract at extended width, compares against the
// rise and fall steps, and selection of the next output.
// ----------------------------------------------------------------------------
module asrl_step (
    input  logic [asrl_pkg::DATA_W-1:0] target,
    input  logic [asrl_pkg::DATA_W-1:0] last_output,
    input  logic                        primed,
    input  asrl_pkg::cfg_t              cfg,
    output logic [asrl_pkg::DATA_W-1:0] limited
);

    logic signed [asrl_pkg::DIFF_W-1:0] tgt_ext;
    logic signed [asrl_pkg::DIFF_W-1:0] last_ext;
    logic signed [asrl_pkg::DIFF_W-1:0] diff;
    logic signed [asrl_pkg::DIFF_W-1:0] up;
    logic signed [asrl_pkg::DIFF_W-1:0] down;
    logic signed [asrl_pkg::DIFF_W-1:0] neg_up;
    logic signed [asrl_pkg::DIFF_W-1:0] neg_down;
    logic signed [asrl_pkg::DIFF_W-1:0] sel;
    logic                               toward_neg;

    assign tgt_ext  = {target[asrl_pkg::DATA_W-1], target};
    assign last_ext = {last_output[asrl_pkg::DATA_W-1], last_output};
    assign diff     = tgt_ext - last_ext;
    assign up       = {2'b00, cfg.rise_step};
    assign down     = {2'b00, cfg.fall_step};
    assign neg_up   = -up;
    assign neg_down = -down;

    // In magnitude mode a negative target swaps the roles of the two steps.
    assign toward_neg = !cfg.sign_mode && target[asrl_pkg::DATA_W-1];

    always_comb
    begin
        if (!primed)
        begin
            sel = tgt_ext;
        end
        else if (cfg.zero_pass && (target == '0))
        begin
            sel = '0;
        end
        else if (!toward_neg)
        begin
            if (diff >= up)
            begin
                sel = last_ext + up;
            end
            else if (diff <= neg_down)
            begin
                sel = last_ext - down;
            end
            else
            begin
                sel = tgt_ext;
            end
        end
        else
        begin
            if (diff <= neg_up)
            begin
                sel = last_ext - up;
            end
            else if (diff >= down)
            begin
                sel = last_ext + down;
            end
            else
            begin
                sel = tgt_ext;
            end
        end
    end

    // A limited result lies between the last output and the target.
    assign limited = sel[asrl_pkg::DATA_W-1:0];

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the asymmetric slew-rate limiter. A queue-fed
// driver and a random-stall receiver exercise both handshakes. A cycle-free
// predictor tracks the last output and the register settings. It checks
// every result beat against the oldest prediction across directed and random
// phases of rise, fall, mode and zero passthrough settings.
// ----------------------------------------------------------------------------
module tb;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   cfg_wr_en = 1'b0;
    logic [asrl_pkg::CFG_INDEX_W-1:0]       cfg_index = asrl_pkg::REG_RISE_STEP;
    logic [asrl_pkg::STEP_W-1:0]            cfg_wdata = '0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic signed [asrl_pkg::DATA_W-1:0]     target = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic signed [asrl_pkg::DATA_W-1:0]     limited;

    logic signed [asrl_pkg::DATA_W-1:0]     target_q[$];
    logic signed [asrl_pkg::DATA_W-1:0]     limited_q[$];
    logic signed [asrl_pkg::DATA_W-1:0]     expected_limited;
    logic signed [asrl_pkg::DATA_W-1:0]     last_limited = '0;
    logic                                   primed = 1'b0;
    logic [asrl_pkg::STEP_W-1:0]            rise_step_m = '0;
    logic [asrl_pkg::STEP_W-1:0]            fall_step_m = '0;
    logic                                   sign_mode_m = 1'b0;
    logic                                   zero_pass_m = 1'b0;

    logic                                   in_taken = 1'b0;
    logic                                   no_idle = 1'b0;
    int unsigned                            send_gap = 0;
    int unsigned                            stall_left = 0;
    int                                     outstanding = 0;
    int                                     errors = 0;

    asymmetric_slew_rate_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .limited   (limited)
    );

    always #1 clk = ~clk;

    function automatic logic signed [asrl_pkg::DATA_W-1:0] next_limited(
        logic signed [asrl_pkg::DATA_W-1:0] tgt);
        longint t;
        longint last;
        longint d;
        longint up;
        longint down;
        longint res;
        t = tgt;
        last = last_limited;
        up = longint'(rise_step_m);
        down = longint'(fall_step_m);
        d = t - last;
        if (!primed)
            res = t;
        else if (zero_pass_m && t == 0)
            res = 0;
        else if (sign_mode_m || t >= 0)
        begin
            if (d >= up)
                res = last + up;
            else if (d <= -down)
                res = last - down;
            else
                res = t;
        end
        else
        begin
            if (d <= -up)
                res = last - up;
            else if (d >= down)
                res = last + down;
            else
                res = t;
        end
        primed = 1'b1;
        last_limited = res[asrl_pkg::DATA_W-1:0];
        return res[asrl_pkg::DATA_W-1:0];
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [asrl_pkg::STEP_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return asrl_pkg::STEP_W'(1);
            2: return asrl_pkg::STEP_W'($urandom_range(2, 50));
            3: return asrl_pkg::STEP_W'($urandom_range(51, 100000));
            4: return asrl_pkg::STEP_W'($urandom);
            default: return {asrl_pkg::STEP_W{1'b1}};
        endcase
    endfunction

    function automatic logic signed [asrl_pkg::DATA_W-1:0] pick_target(
        logic signed [asrl_pkg::DATA_W-1:0] prev, int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom;
        else if (r < 35)
            return $signed($urandom_range(0, 2000)) - 1000;
        else if (r < 45)
            return '0;
        else if (r < 55)
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return -1;
                default: return 1;
            endcase
        else
            return prev + $signed(asrl_pkg::DATA_W'($urandom_range(0, 2 * span)))
                   - $signed(span);
    endfunction

    task automatic write_reg(asrl_pkg::cfg_index_t idx, logic [asrl_pkg::STEP_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            asrl_pkg::REG_RISE_STEP: rise_step_m = value;
            asrl_pkg::REG_FALL_STEP: fall_step_m = value;
            asrl_pkg::REG_SIGN_MODE: sign_mode_m = value[0];
            asrl_pkg::REG_ZERO_PASS: zero_pass_m = value[0];
            default: ;
        endcase
    endtask

    // Flag registers get random upper bits, which the block must ignore.
    task automatic set_config(logic [asrl_pkg::STEP_W-1:0] rise,
                              logic [asrl_pkg::STEP_W-1:0] fall,
                              logic mode, logic zpass);
        write_reg(asrl_pkg::REG_RISE_STEP, rise);
        write_reg(asrl_pkg::REG_FALL_STEP, fall);
        write_reg(asrl_pkg::REG_SIGN_MODE,
                  (asrl_pkg::STEP_W'($urandom) & ~asrl_pkg::STEP_W'(1))
                  | asrl_pkg::STEP_W'(mode));
        write_reg(asrl_pkg::REG_ZERO_PASS,
                  (asrl_pkg::STEP_W'($urandom) & ~asrl_pkg::STEP_W'(1))
                  | asrl_pkg::STEP_W'(zpass));
    endtask

    task automatic push_target(logic signed [asrl_pkg::DATA_W-1:0] t);
        target_q.push_back(t);
        outstanding++;
    endtask

    task automatic settle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (target_q.size() != 0)
            begin
                in_valid <= 1'b1;
                target <= target_q.pop_front();
                send_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= pick_gap();
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (limited_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got %0d",
                             $time, limited);
                    errors++;
                end
                else
                begin
                    expected_limited = limited_q.pop_front();
                    outstanding--;
                    if (limited !== expected_limited)
                    begin
                        $display("%0t: limited mismatch, expected %0d, got %0d",
                                 $time, expected_limited, limited);
                        errors++;
                    end
                end
            end
            in_taken = in_valid && !in_stall;
            if (in_taken)
                limited_q.push_back(next_limited(target));
        end
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int p;
        int n;
        int unsigned span;
        logic signed [asrl_pkg::DATA_W-1:0] t;
        logic [asrl_pkg::STEP_W-1:0] rise;
        logic [asrl_pkg::STEP_W-1:0] fall;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings hold the output after the first beat passes through.
        push_target(32'h8000_0000);
        push_target(32'h7FFF_FFFF);
        push_target(0);
        settle();

        set_config({asrl_pkg::STEP_W{1'b1}}, {asrl_pkg::STEP_W{1'b1}}, 1'b1, 1'b0);
        push_target(32'h7FFF_FFFF);
        push_target(32'h8000_0000);
        settle();

        set_config(5, 3, 1'b0, 1'b1);
        push_target(0);
        push_target(7);
        push_target(5);
        push_target(-9);
        push_target(-2);
        push_target(0);
        push_target(-3);
        push_target(32'h7FFF_FFFF);
        push_target(32'h8000_0000);
        settle();

        set_config(5, 3, 1'b1, 1'b1);
        push_target(0);
        push_target(10);
        push_target(-10);
        push_target(0);
        push_target(4);
        push_target(1);
        settle();

        t = 0;
        for (p = 0; p < 12; p++)
        begin
            if (p == 0)
            begin
                rise = {asrl_pkg::STEP_W{1'b1}};
                fall = {asrl_pkg::STEP_W{1'b1}};
            end
            else if (p == 1)
            begin
                rise = '0;
                fall = '0;
            end
            else
            begin
                rise = pick_step();
                fall = pick_step();
            end
            set_config(rise, fall, 1'($urandom), 1'($urandom));
            no_idle = ($urandom_range(0, 3) == 0);
            span = ((rise > 50000) ? 50000 : rise) + ((fall > 50000) ? 50000 : fall) + 4;
            for (n = 0; n < 111; n++)
            begin
                t = pick_target(t, span);
                push_target(t);
            end
            settle();
        end

        no_idle = 1'b0;
        repeat (8) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/asrl_pkg.sv
hw/rtl/asrl_cfg.sv
hw/rtl/asrl_step.sv
hw/rtl/asymmetric_slew_rate_limiter.sv
tb/sv/tb.sv
